[rtl/qwrf_pkg.sv]
package qwrf_pkg;

	localparam int DEF_MAX_WINDOW    = 64;
	localparam int DEF_POSITION_BITS = 16;

	localparam int RESULT_BITS   = 16;
	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int WIN_CFG_BITS  = 7;
	localparam int RUN_CFG_BITS  = 16;

	localparam logic [WIN_CFG_BITS-1:0] RST_WINDOW_SIZE = 7'd6;
	localparam logic [WIN_CFG_BITS-1:0] RST_MIN_GOOD    = 7'd3;
	localparam logic [RUN_CFG_BITS-1:0] RST_MIN_RUN     = 16'd20;

	localparam logic [7:0] CHAR_HQ_FIRST = 8'h41;
	localparam logic [7:0] CHAR_HQ_LAST  = 8'h5A;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_MIN_GOOD    = 2'd1,
		REG_MIN_RUN     = 2'd2
	} qwrf_reg_t;

	typedef struct packed {
		logic last;
		logic judge;
		logic ovf;
	} qwrf_ctl_t;

endpackage

[rtl/quality_window_run_finder_core.sv]
// A read's result passes from the stage-1 registers to the output register after its last
// character transfers, and is held there until the output transfers it.
// Throughput: one character per cycle; the input stalls only while a finished result
// waits on the output and the next last character is ready to report.
// Window count is a masked popcount tree over the flag shift register.
// Reset (arst_n low): configuration returns to 6 / 3 / 20, all read state and both
// pipeline valids clear; no clearing pass is needed.
module quality_window_run_finder_core
	import qwrf_pkg::*;
#(
	parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
	parameter int POSITION_BITS = DEF_POSITION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [7:0]               s_axis_tdata,   // [7:0] base_char
	input  logic                     s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [2*RESULT_BITS-1:0] m_axis_tdata,   // [15:0] run_start, [31:16] run_end
	output logic [1:0]               m_axis_tuser,   // [0] run_found, [1] length_overflow
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int CNTW = $clog2(MAX_WINDOW + 1);
	localparam int EW   = (CNTW > WIN_CFG_BITS ? CNTW : WIN_CFG_BITS);

	logic [WIN_CFG_BITS-1:0]  window_size_q;
	logic [WIN_CFG_BITS-1:0]  min_good_q;
	logic [RUN_CFG_BITS-1:0]  min_run_q;

	logic [EW-1:0]            ws_ext;
	logic [CNTW-1:0]          win;
	logic                     accept;
	qwrf_ctl_t                ctl_s1;
	logic [CNTW-1:0]          count_s1;
	logic [POSITION_BITS-1:0] len_s1;
	logic [POSITION_BITS-1:0] start_s1;
	logic                     out_found;
	logic                     out_ovf;
	logic [RESULT_BITS-1:0]   out_start;
	logic [RESULT_BITS-1:0]   out_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= RST_WINDOW_SIZE;
			min_good_q    <= RST_MIN_GOOD;
			min_run_q     <= RST_MIN_RUN;
		end else if (cfg_we) begin
			case (qwrf_reg_t'(cfg_addr))
				REG_WINDOW_SIZE: window_size_q <= cfg_wdata[WIN_CFG_BITS-1:0];
				REG_MIN_GOOD:    min_good_q    <= cfg_wdata[WIN_CFG_BITS-1:0];
				REG_MIN_RUN:     min_run_q     <= cfg_wdata[RUN_CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign ws_ext = EW'(window_size_q);

	always_comb begin
		if (ws_ext == '0) begin
			win = CNTW'(1);
		end else if (ws_ext > EW'(MAX_WINDOW)) begin
			win = CNTW'(MAX_WINDOW);
		end else begin
			win = CNTW'(ws_ext);
		end
	end

	assign accept = s_axis_tvalid & s_axis_tready;

	qwrf_front #(
		.MAX_WINDOW   (MAX_WINDOW),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.base_char   (s_axis_tdata),
		.last_in_read(s_axis_tlast),
		.win         (win),
		.ctl_s1      (ctl_s1),
		.count_s1    (count_s1),
		.len_s1      (len_s1),
		.start_s1    (start_s1)
	);

	qwrf_judge #(
		.MAX_WINDOW   (MAX_WINDOW),
		.POSITION_BITS(POSITION_BITS)
	) u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_ready (s_axis_tready),
		.ctl_s1   (ctl_s1),
		.count_s1 (count_s1),
		.len_s1   (len_s1),
		.start_s1 (start_s1),
		.win      (win),
		.min_good (min_good_q),
		.min_run  (min_run_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_found(out_found),
		.out_start(out_start),
		.out_end  (out_end),
		.out_ovf  (out_ovf)
	);

	assign m_axis_tdata = {out_end, out_start};
	assign m_axis_tuser = {out_ovf, out_found};

endmodule

[rtl/qwrf_popcount.sv]
module qwrf_popcount
	import qwrf_pkg::*;
#(
	parameter int WIDTH = DEF_MAX_WINDOW,
	localparam int SUMW = $clog2(WIDTH + 1)
) (
	input  logic [WIDTH-1:0] bits,
	output logic [SUMW-1:0]  sum
);

	localparam int LEVELS = $clog2(WIDTH);
	localparam int LEAVES = 1 << LEVELS;

	logic [SUMW-1:0] node [1:2*LEAVES-1];

	for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
		if (g < WIDTH) begin : g_used
			assign node[LEAVES+g] = SUMW'(bits[g]);
		end else begin : g_pad
			assign node[LEAVES+g] = '0;
		end
	end

	for (genvar k = 1; k < LEAVES; k++) begin : g_add
		assign node[k] = node[2*k] + node[2*k+1];
	end

	assign sum = node[1];

endmodule

[rtl/qwrf_front.sv]
module qwrf_front
	import qwrf_pkg::*;
#(
	parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	localparam int CNTW = $clog2(MAX_WINDOW + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               base_char,
	input  logic                     last_in_read,
	input  logic [CNTW-1:0]          win,
	output qwrf_ctl_t                ctl_s1,
	output logic [CNTW-1:0]          count_s1,
	output logic [POSITION_BITS-1:0] len_s1,
	output logic [POSITION_BITS-1:0] start_s1
);

	localparam int CW = (POSITION_BITS > CNTW ? POSITION_BITS : CNTW) + 1;

	logic [MAX_WINDOW-1:0]    flags_q;
	logic [POSITION_BITS-1:0] position_q;
	logic                     overflowed_q;

	logic [MAX_WINDOW-1:0]    flags_next;
	logic [MAX_WINDOW-1:0]    win_mask;
	logic [POSITION_BITS-1:0] pos_next;
	logic [CW-1:0]            pos_ext;
	logic [CW-1:0]            win_ext;
	logic [CNTW-1:0]          count;
	logic                     taken;
	logic                     hq;

	assign hq    = (base_char >= CHAR_HQ_FIRST) && (base_char <= CHAR_HQ_LAST);
	assign taken = (position_q != '1);

	assign flags_next = taken ? ((flags_q << 1) | MAX_WINDOW'(hq)) : flags_q;
	assign pos_next   = position_q + POSITION_BITS'(taken);
	assign pos_ext    = CW'(pos_next);
	assign win_ext    = CW'(win);

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_mask
		assign win_mask[i] = (CNTW'(i) < win);
	end

	qwrf_popcount #(
		.WIDTH(MAX_WINDOW)
	) u_popcount (
		.bits(flags_next & win_mask),
		.sum (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			position_q   <= '0;
			overflowed_q <= 1'b0;
		end else if (accept) begin
			if (last_in_read) begin
				flags_q      <= '0;
				position_q   <= '0;
				overflowed_q <= 1'b0;
			end else begin
				flags_q      <= flags_next;
				position_q   <= pos_next;
				overflowed_q <= overflowed_q | ~taken;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.last  <= last_in_read;
			ctl_s1.judge <= taken && (pos_ext >= win_ext);
			ctl_s1.ovf   <= overflowed_q | ~taken;
			count_s1     <= count;
			len_s1       <= pos_next;
			start_s1     <= POSITION_BITS'(pos_ext - win_ext);
		end
	end

endmodule

[rtl/qwrf_judge.sv]
module qwrf_judge
	import qwrf_pkg::*;
#(
	parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	localparam int CNTW = $clog2(MAX_WINDOW + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	output logic                     in_ready,
	input  qwrf_ctl_t                ctl_s1,
	input  logic [CNTW-1:0]          count_s1,
	input  logic [POSITION_BITS-1:0] len_s1,
	input  logic [POSITION_BITS-1:0] start_s1,
	input  logic [CNTW-1:0]          win,
	input  logic [WIN_CFG_BITS-1:0]  min_good,
	input  logic [RUN_CFG_BITS-1:0]  min_run,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_found,
	output logic [RESULT_BITS-1:0]   out_start,
	output logic [RESULT_BITS-1:0]   out_end,
	output logic                     out_ovf
);

	localparam int GW = (CNTW > WIN_CFG_BITS ? CNTW : WIN_CFG_BITS);
	localparam int LW = (POSITION_BITS > RUN_CFG_BITS ? POSITION_BITS : RUN_CFG_BITS) + 1;
	localparam int CW = (POSITION_BITS > CNTW ? POSITION_BITS : CNTW) + 1;

	logic                     s1_valid_q;
	logic                     out_valid_q;
	logic [POSITION_BITS-1:0] run_begin_q, found_begin_q, found_end_q;
	logic                     run_locked_q, in_run_q, run_closed_q;

	logic [POSITION_BITS-1:0] run_begin_n, found_begin_n, found_end_n;
	logic                     run_locked_n, in_run_n, run_closed_n;
	logic [POSITION_BITS-1:0] begin_eff;
	logic [LW-1:0]            span;
	logic [LW-1:0]            tail;
	logic                     good;
	logic                     advance;
	logic                     res_found;
	logic [LW-1:0]            res_start, res_end;

	assign advance  = ~ctl_s1.last | ~out_valid_q | out_ready;
	assign in_ready = ~s1_valid_q | advance;

	assign good      = (min_good != '0) && (GW'(count_s1) >= GW'(min_good));
	assign begin_eff = in_run_q ? run_begin_q : start_s1;
	assign span      = LW'(start_s1) - LW'(begin_eff) + LW'(1);

	always_comb begin
		run_begin_n   = run_begin_q;
		found_begin_n = found_begin_q;
		found_end_n   = found_end_q;
		run_locked_n  = run_locked_q;
		in_run_n      = in_run_q;
		run_closed_n  = run_closed_q;
		if (ctl_s1.judge) begin
			if (run_locked_q) begin
				if (!run_closed_q && !good) begin
					found_end_n  = start_s1;
					run_closed_n = 1'b1;
				end
			end else if (good) begin
				run_begin_n = begin_eff;
				in_run_n    = 1'b1;
				if (span >= LW'(min_run)) begin
					run_locked_n  = 1'b1;
					found_begin_n = begin_eff;
				end
			end else begin
				in_run_n = 1'b0;
				if (min_run == '0) begin
					run_locked_n  = 1'b1;
					run_closed_n  = 1'b1;
					found_begin_n = start_s1;
					found_end_n   = start_s1;
				end
			end
		end
	end

	assign tail = LW'(len_s1) - LW'(run_begin_n);

	always_comb begin
		res_found = 1'b0;
		res_start = LW'(len_s1);
		res_end   = LW'(len_s1);
		if (ctl_s1.ovf) begin
			res_start = LW'({RESULT_BITS{1'b1}});
			res_end   = LW'({RESULT_BITS{1'b1}});
		end else if (CW'(len_s1) >= CW'(win)) begin
			if (run_locked_n) begin
				res_found = 1'b1;
				res_start = LW'(found_begin_n);
				res_end   = run_closed_n ? LW'(found_end_n) : LW'(len_s1);
			end else if (in_run_n && (tail >= LW'(min_run))) begin
				res_found = 1'b1;
				res_start = LW'(run_begin_n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			run_begin_q   <= '0;
			found_begin_q <= '0;
			found_end_q   <= '0;
			run_locked_q  <= 1'b0;
			in_run_q      <= 1'b0;
			run_closed_q  <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_valid_q && advance && ctl_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_valid_q && advance) begin
				if (ctl_s1.last) begin
					run_begin_q   <= '0;
					found_begin_q <= '0;
					found_end_q   <= '0;
					run_locked_q  <= 1'b0;
					in_run_q      <= 1'b0;
					run_closed_q  <= 1'b0;
				end else begin
					run_begin_q   <= run_begin_n;
					found_begin_q <= found_begin_n;
					found_end_q   <= found_end_n;
					run_locked_q  <= run_locked_n;
					in_run_q      <= in_run_n;
					run_closed_q  <= run_closed_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && advance && ctl_s1.last) begin
			out_found <= res_found;
			out_start <= res_start[RESULT_BITS-1:0];
			out_end   <= res_end[RESULT_BITS-1:0];
			out_ovf   <= ctl_s1.ovf;
		end
	end

	assign out_valid = out_valid_q;

endmodule
